@@ rtl/core/slb_pkg.sv @@
// Shared types and constants of the seam linear blend block.
// Depends on nothing; imported by every module under rtl/core.
package slb_pkg;

    localparam int CH_W          = 8;
    localparam int NUM_CH        = 3;
    localparam int K_W           = 12;
    localparam int CFG_W         = 13;
    localparam int MAX_WIDTH_DEF = 4096;

    typedef struct packed {
        logic [K_W-1:0]  column_offset;
        logic [CH_W-1:0] base_ch0;
        logic [CH_W-1:0] base_ch1;
        logic [CH_W-1:0] base_ch2;
        logic [CH_W-1:0] warped_ch0;
        logic [CH_W-1:0] warped_ch1;
        logic [CH_W-1:0] warped_ch2;
    } t_pix_in;

    typedef struct packed {
        logic [CH_W-1:0] blended_ch0;
        logic [CH_W-1:0] blended_ch1;
        logic [CH_W-1:0] blended_ch2;
    } t_pix_out;

    typedef logic [NUM_CH-1:0][CH_W-1:0] t_chan;

    typedef struct packed {
        logic  vld;
        logic  black;
        t_chan base;
    } t_ctl;

endpackage

@@ rtl/core/slb_prep.sv @@
// Front stages of the blend: offset clamp, weight products and numerator sum.
// Depends on slb_pkg; feeds the divide stages in slb_div.
module slb_prep
    import slb_pkg::*;
#(
    parameter int W_W = 13
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_vld,
    input  t_pix_in                           i_data,
    input  logic [W_W-1:0]                    i_wd,
    output t_ctl                              o_ctl,
    output logic [NUM_CH-1:0][CH_W+W_W-1:0]   o_num
);

    localparam int NW   = CH_W + W_W;
    localparam int KC_W = (W_W > K_W) ? W_W : K_W;

    logic [KC_W-1:0] k_ext;
    logic [KC_W-1:0] wd_ext;
    logic            k_ge;
    logic [W_W-1:0]  n1_k;
    logic [W_W-1:0]  n1_wk;
    logic            n1_black;
    t_chan           n1_base;
    t_chan           n1_warp;

    logic            r1_vld;
    logic            r1_black;
    t_chan           r1_base;
    t_chan           r1_warp;
    logic [W_W-1:0]  r1_k;
    logic [W_W-1:0]  r1_wk;

    logic                       r2_vld;
    logic                       r2_black;
    t_chan                      r2_base;
    logic [NUM_CH-1:0][NW-1:0]  n2_pb;
    logic [NUM_CH-1:0][NW-1:0]  n2_pw;
    logic [NUM_CH-1:0][NW-1:0]  r2_pb;
    logic [NUM_CH-1:0][NW-1:0]  r2_pw;

    logic                       r3_vld;
    logic                       r3_black;
    t_chan                      r3_base;
    logic [NUM_CH-1:0][NW-1:0]  n3_num;
    logic [NUM_CH-1:0][NW-1:0]  r3_num;

    always_comb begin
        n1_base  = {i_data.base_ch2, i_data.base_ch1, i_data.base_ch0};
        n1_warp  = {i_data.warped_ch2, i_data.warped_ch1, i_data.warped_ch0};
        n1_black = (n1_warp == '0);
        k_ext    = KC_W'(i_data.column_offset);
        wd_ext   = KC_W'(i_wd);
        k_ge     = (k_ext >= wd_ext);
        n1_k     = k_ge ? (i_wd - W_W'(1)) : W_W'(k_ext);
        n1_wk    = k_ge ? W_W'(1) : (i_wd - W_W'(k_ext));
    end

    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            n2_pb[c]  = NW'(r1_base[c]) * NW'(r1_wk);
            n2_pw[c]  = NW'(r1_warp[c]) * NW'(r1_k);
            n3_num[c] = r2_pb[c] + r2_pw[c];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_vld;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_black <= n1_black;
            r1_base  <= n1_base;
            r1_warp  <= n1_warp;
            r1_k     <= n1_k;
            r1_wk    <= n1_wk;
            r2_black <= r1_black;
            r2_base  <= r1_base;
            r2_pb    <= n2_pb;
            r2_pw    <= n2_pw;
            r3_black <= r2_black;
            r3_base  <= r2_base;
            r3_num   <= n3_num;
        end
    end

    assign o_ctl = '{vld: r3_vld, black: r3_black, base: r3_base};
    assign o_num = r3_num;

endmodule

@@ rtl/core/slb_div.sv @@
// One restoring divide stage: resolves one quotient bit for each channel.
// Depends on slb_pkg; chained by the top level, one stage per quotient bit.
module slb_div
    import slb_pkg::*;
#(
    parameter int W_W   = 13,
    parameter int SHIFT = 0
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic [W_W-1:0]                    i_wd,
    input  t_ctl                              i_ctl,
    input  logic [NUM_CH-1:0][CH_W+W_W-1:0]   i_rem,
    input  t_chan                             i_quo,
    output t_ctl                              o_ctl,
    output logic [NUM_CH-1:0][CH_W+W_W-1:0]   o_rem,
    output t_chan                             o_quo
);

    localparam int NW = CH_W + W_W;

    logic [NW-1:0]             dvs;
    logic [NUM_CH-1:0][NW-1:0] n_rem;
    t_chan                     n_quo;
    logic                      r_vld;
    logic                      r_black;
    t_chan                     r_base;
    logic [NUM_CH-1:0][NW-1:0] r_rem;
    t_chan                     r_quo;

    always_comb begin
        dvs = NW'(i_wd) << SHIFT;
        for (int c = 0; c < NUM_CH; c++) begin
            if (i_rem[c] >= dvs) begin
                n_rem[c] = i_rem[c] - dvs;
                n_quo[c] = i_quo[c] | (CH_W'(1) << SHIFT);
            end else begin
                n_rem[c] = i_rem[c];
                n_quo[c] = i_quo[c];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_ctl.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_black <= i_ctl.black;
            r_base  <= i_ctl.base;
            r_rem   <= n_rem;
            r_quo   <= n_quo;
        end
    end

    assign o_ctl = '{vld: r_vld, black: r_black, base: r_base};
    assign o_rem = r_rem;
    assign o_quo = r_quo;

endmodule

@@ rtl/core/seam_linear_blend.sv @@
// Seam linear blend: feathers base and warped pixels across a stitching overlap.
// Depends on slb_pkg, slb_prep and slb_div.
//
// Takes one pixel per clock while the output is not stalled and returns one
// blended pixel per pixel, in order. Three front stages clamp the offset, form
// the two weight products and sum them; eight divide stages then resolve the
// quotient by the overlap width one bit per stage. An input skid register keeps
// the input ready a registered signal. Write the overlap width only while no
// pixel is in flight; 0 acts as 1 and widths above MAX_WIDTH act as MAX_WIDTH.
module seam_linear_blend
    import slb_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_pix_in          i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_pix_out         o_out_data,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata
);

    localparam int W_W   = $clog2(MAX_WIDTH + 1);
    localparam int NW    = CH_W + W_W;
    localparam int CMP_W = (W_W > CFG_W) ? W_W : CFG_W;

    logic [W_W-1:0]   r_wd;
    logic [CMP_W-1:0] cfg_ext;
    logic [W_W-1:0]   n_wd;

    logic             r_sk_vld;
    t_pix_in          r_sk_data;
    logic             src_vld;
    t_pix_in          src_data;
    logic             en;

    t_ctl                      ctl [CH_W+1];
    t_chan                     quo [CH_W+1];
    logic [NUM_CH-1:0][NW-1:0] rem [CH_W];
    t_chan                     blended;

    always_comb begin
        cfg_ext = CMP_W'(i_cfg_wdata);
        if (cfg_ext == '0) begin
            n_wd = W_W'(1);
        end else if (cfg_ext > CMP_W'(MAX_WIDTH)) begin
            n_wd = W_W'(MAX_WIDTH);
        end else begin
            n_wd = W_W'(cfg_ext);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wd <= W_W'(1);
        end else if (i_cfg_we) begin
            r_wd <= n_wd;
        end
    end

    // hold a beat in the skid register while the pipe is stalled
    assign en         = !ctl[CH_W].vld || i_out_ready;
    assign o_in_ready = !r_sk_vld;
    assign src_vld    = r_sk_vld || i_in_valid;
    assign src_data   = r_sk_vld ? r_sk_data : i_in_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sk_vld <= 1'b0;
        end else if (en) begin
            r_sk_vld <= 1'b0;
        end else if (i_in_valid && !r_sk_vld) begin
            r_sk_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!en && i_in_valid && !r_sk_vld) begin
            r_sk_data <= i_in_data;
        end
    end

    slb_prep #(
        .W_W (W_W)
    ) u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (src_vld),
        .i_data  (src_data),
        .i_wd    (r_wd),
        .o_ctl   (ctl[0]),
        .o_num   (rem[0])
    );

    assign quo[0] = '0;

    for (genvar g = 0; g < CH_W; g++) begin : g_div
        if (g < CH_W - 1) begin : g_mid
            slb_div #(
                .W_W   (W_W),
                .SHIFT (CH_W - 1 - g)
            ) u_div (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_en    (en),
                .i_wd    (r_wd),
                .i_ctl   (ctl[g]),
                .i_rem   (rem[g]),
                .i_quo   (quo[g]),
                .o_ctl   (ctl[g+1]),
                .o_rem   (rem[g+1]),
                .o_quo   (quo[g+1])
            );
        end else begin : g_last
            slb_div #(
                .W_W   (W_W),
                .SHIFT (CH_W - 1 - g)
            ) u_div (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_en    (en),
                .i_wd    (r_wd),
                .i_ctl   (ctl[g]),
                .i_rem   (rem[g]),
                .i_quo   (quo[g]),
                .o_ctl   (ctl[g+1]),
                .o_rem   (),
                .o_quo   (quo[g+1])
            );
        end
    end

    // pass the base pixel through when the warped pixel is black
    assign blended     = ctl[CH_W].black ? ctl[CH_W].base : quo[CH_W];
    assign o_out_valid = ctl[CH_W].vld;
    assign o_out_data  = '{blended_ch0: blended[0],
                           blended_ch1: blended[1],
                           blended_ch2: blended[2]};

endmodule

@@ tb/sv/seam_linear_blend_tb.sv @@
// Self-checking testbench for seam_linear_blend: directed table, then random pixels
// across many overlap widths, checked against an in-bench predictor of the feather blend.
// Depends on slb_pkg and the RTL under rtl/core.
module seam_linear_blend_tb;
    import slb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned MAX_W       = MAX_WIDTH_DEF;
    localparam int          IDLE_LIMIT  = 2000;
    localparam int          HOLD_CYCLES = 64;
    localparam int          PHASE_ITEMS = 70;
    localparam int          NUM_PHASES  = 15;

    typedef struct {
        logic [CFG_W-1:0] width;
        t_pix_in          pix;
        bit               typed;
        t_pix_out         exp;
    } t_row;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_in_valid;
    logic             o_in_ready;
    t_pix_in          i_in_data;
    logic             o_out_valid;
    logic             i_out_ready;
    t_pix_out         o_out_data;
    logic             i_cfg_we;
    logic [CFG_W-1:0] i_cfg_wdata;

    t_pix_out         due_pixels[$];
    logic [CFG_W-1:0] cfg_width;
    bit               send_fast;
    bit               recv_fast;
    bit               hold_req;
    int               mismatches;
    int               pixels_sent;
    int               black_sent;
    int               beats_checked;
    int               widths_used;
    int               idle_cycles;

    const logic [CFG_W-1:0] phase_widths[NUM_PHASES] = '{
        13'd1, 13'd2, 13'd3, 13'd5, 13'd16, 13'd255, 13'd640, 13'd1000,
        13'd2047, 13'd4095, 13'd4096, 13'd4097, 13'd8191, 13'd0, 13'd7
    };

    const t_row dir_rows[19] = '{
        '{13'd1,    {12'd0,    48'hffffff_000000}, 1'b1, 24'hffffff},
        '{13'd1,    {12'd4095, 48'h123456_ffffff}, 1'b1, 24'h123456},
        '{13'd1,    {12'd0,    48'h000000_010000}, 1'b1, 24'h000000},
        '{13'd1,    {12'd2048, 48'h807f01_000080}, 1'b1, 24'h807f01},
        '{13'd4096, {12'd0,    48'ha55aff_ff0080}, 1'b1, 24'ha55aff},
        '{13'd4096, {12'd4095, 48'hffffff_000001}, 1'b0, 24'h0},
        '{13'd4096, {12'd2048, 48'h000000_ffffff}, 1'b0, 24'h0},
        '{13'd4096, {12'd2048, 48'h112233_000000}, 1'b1, 24'h112233},
        '{13'd4096, {12'd4095, 48'h000000_ffffff}, 1'b0, 24'h0},
        '{13'd0,    {12'd100,  48'h010203_ffffff}, 1'b1, 24'h010203},
        '{13'd8191, {12'd4095, 48'h000000_ffffff}, 1'b0, 24'h0},
        '{13'd8191, {12'd1,    48'hffffff_000001}, 1'b0, 24'h0},
        '{13'd4097, {12'd4095, 48'hff00ff_00ff00}, 1'b0, 24'h0},
        '{13'd2,    {12'd1,    48'hff0080_00ff81}, 1'b0, 24'h0},
        '{13'd2,    {12'd2,    48'hff0080_00ff81}, 1'b0, 24'h0},
        '{13'd2,    {12'd0,    48'haabbcc_000000}, 1'b1, 24'haabbcc},
        '{13'd3,    {12'd1,    48'hffffff_fefefe}, 1'b0, 24'h0},
        '{13'd3,    {12'd3,    48'h000102_ffffff}, 1'b0, 24'h0},
        '{13'd3,    {12'd4095, 48'h102030_000000}, 1'b1, 24'h102030}
    };

    seam_linear_blend #(
        .MAX_WIDTH(MAX_W)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic int unsigned eff_width(logic [CFG_W-1:0] w_reg);
        if (w_reg == '0) begin
            return 1;
        end
        if (w_reg > MAX_W) begin
            return MAX_W;
        end
        return 32'(w_reg);
    endfunction

    function automatic t_pix_out blend_pixel(t_pix_in p, logic [CFG_W-1:0] w_reg);
        int unsigned wd;
        int unsigned k;
        int unsigned b[3];
        int unsigned w[3];
        int unsigned o[3];
        t_pix_out    r;
        wd = eff_width(w_reg);
        k  = 32'(p.column_offset);
        if (k >= wd) begin
            k = wd - 1;
        end
        b = '{32'(p.base_ch0), 32'(p.base_ch1), 32'(p.base_ch2)};
        w = '{32'(p.warped_ch0), 32'(p.warped_ch1), 32'(p.warped_ch2)};
        for (int c = 0; c < 3; c++) begin
            if (w[0] == 0 && w[1] == 0 && w[2] == 0) begin
                o[c] = b[c];
            end else begin
                o[c] = (b[c] * (wd - k) + w[c] * k) / wd;
            end
        end
        r.blended_ch0 = o[0][CH_W-1:0];
        r.blended_ch1 = o[1][CH_W-1:0];
        r.blended_ch2 = o[2][CH_W-1:0];
        return r;
    endfunction

    function automatic logic [CH_W-1:0] rand_byte();
        case ($urandom_range(0, 7))
            0: begin
                return 8'h00;
            end
            1: begin
                return 8'hff;
            end
            default: begin
                return CH_W'($urandom_range(0, 255));
            end
        endcase
    endfunction

    function automatic t_pix_in rand_pixel(logic [CFG_W-1:0] w_reg);
        int unsigned wd;
        t_pix_in     p;
        wd = eff_width(w_reg);
        case ($urandom_range(0, 9))
            0: begin
                p.column_offset = '0;
            end
            1: begin
                p.column_offset = K_W'(wd - 1);
            end
            2, 3: begin
                p.column_offset = K_W'($urandom_range(0, 4095));
            end
            default: begin
                p.column_offset = K_W'($urandom_range(0, wd - 1));
            end
        endcase
        p.base_ch0 = rand_byte();
        p.base_ch1 = rand_byte();
        p.base_ch2 = rand_byte();
        if ($urandom_range(0, 7) == 0) begin
            p.warped_ch0 = '0;
            p.warped_ch1 = '0;
            p.warped_ch2 = '0;
        end else begin
            p.warped_ch0 = rand_byte();
            p.warped_ch1 = rand_byte();
            p.warped_ch2 = rand_byte();
        end
        return p;
    endfunction

    task automatic send_pixel(t_pix_in p, bit typed, t_pix_out typed_exp);
        int gap;
        gap = send_fast ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_data  <= p;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        due_pixels.insert(due_pixels.size(), typed ? typed_exp : blend_pixel(p, cfg_width));
        pixels_sent++;
        if ({p.warped_ch0, p.warped_ch1, p.warped_ch2} == '0) begin
            black_sent++;
        end
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (due_pixels.size() != 0);
        repeat (2) @(negedge i_clk);
    endtask

    task automatic write_width(logic [CFG_W-1:0] w);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= w;
        @(negedge i_clk);
        i_cfg_we  <= 1'b0;
        cfg_width = w;
        widths_used++;
    endtask

    function automatic void check_field(string name, logic [CH_W-1:0] e, logic [CH_W-1:0] a);
        if (a !== e) begin
            mismatches++;
            $error("%s: expected %0h, got %0h", name, e, a);
        end
    endfunction

    // Checker and watchdog.
    always @(posedge i_clk) begin
        t_pix_out e;
        bit       in_beat;
        bit       out_beat;
        in_beat  = i_rst_n && i_in_valid && o_in_ready;
        out_beat = i_rst_n && o_out_valid === 1'b1 && i_out_ready;
        if (out_beat) begin
            if (due_pixels.size() == 0) begin
                mismatches++;
                $error("output beat with no pixel pending: %0h", o_out_data);
            end else begin
                e = due_pixels.pop_front();
                check_field("blended_ch0", e.blended_ch0, o_out_data.blended_ch0);
                check_field("blended_ch1", e.blended_ch1, o_out_data.blended_ch1);
                check_field("blended_ch2", e.blended_ch2, o_out_data.blended_ch2);
                beats_checked++;
            end
        end
        if (i_rst_n) begin
            if (in_beat || out_beat) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Timeout: no beat for %0d cycles", IDLE_LIMIT);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // Output side: random stalls, fast stretches, and a long hold on each request.
    initial begin
        int gap;
        int n;
        i_out_ready = 1'b0;
        n = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (n % 16 == 0) begin
                recv_fast = ($urandom_range(0, 3) == 0);
            end
            n++;
            if (hold_req) begin
                hold_req = 1'b0;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            gap = recv_fast ? 0 : $urandom_range(0, 4);
            if (gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
        end
    end

    // Input side and run control.
    initial begin
        t_pix_in px;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_in_data     = '0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        cfg_width     = 13'd1;
        send_fast     = 1'b0;
        hold_req      = 1'b0;
        mismatches    = 0;
        pixels_sent   = 0;
        black_sent    = 0;
        beats_checked = 0;
        widths_used   = 1;
        idle_cycles   = 0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_rows[r]) begin
            if (dir_rows[r].width != cfg_width) begin
                drain();
                write_width(dir_rows[r].width);
            end
            send_pixel(dir_rows[r].pix, dir_rows[r].typed, dir_rows[r].exp);
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            drain();
            write_width(phase_widths[ph]);
            if (ph == 2 || ph == 9) begin
                hold_req = 1'b1;
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 20 == 0) begin
                    send_fast = ($urandom_range(0, 3) == 0);
                end
                px = rand_pixel(cfg_width);
                send_pixel(px, 1'b0, '0);
            end
        end

        drain();
        repeat (20) @(negedge i_clk);
        if (due_pixels.size() != 0) begin
            mismatches++;
            $error("%0d expected pixels never came out", due_pixels.size());
        end
        $display("Run covered %0d pixels (%0d with black warped input) over %0d width settings,",
                 pixels_sent, black_sent, widths_used);
        $display("%0d blended beats compared, %0d field errors.", beats_checked, mismatches);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/slb_pkg.sv
rtl/core/slb_prep.sv
rtl/core/slb_div.sv
rtl/core/seam_linear_blend.sv
tb/sv/seam_linear_blend_tb.sv
